// File: rtl/core/etl_pkg.sv
// ----------------------------------------------------------------------------
// etl_pkg: shared types and constants for the tour length block
// Field widths, parameter defaults, command codes and controller states.
// ----------------------------------------------------------------------------
package etl_pkg;

  localparam int IDX_W          = 10;
  localparam int IN_COORD_W     = 16;
  localparam int SUM_W          = 40;

  localparam int MAX_CITIES_DEF = 1024;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_VISIT = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_B,
    ST_DIFF,
    ST_MUL,
    ST_START,
    ST_ROOT,
    ST_ACC,
    ST_EMIT
  } state_t;

endpackage

// File: rtl/core/euclidean_tour_length.sv
// ----------------------------------------------------------------------------
// euclidean_tour_length: closed tour length over a stored city table
// Loads write city coordinates; visits accumulate leg lengths worked out
// on the fly, and the last visit returns the saturating closed-tour total.
// ----------------------------------------------------------------------------
//   channel   handshake              payload
//   request   cmd_valid / cmd_ready  command, city_index, x_coord, y_coord,
//                                    last_city
//   result    res_valid / res_ready  tour_length, saturated
//
// A load, and the first visit of a tour, complete in the idle state; a
// one-city tour then adds an emit step for its result. Every later visit
// computes one leg: two coordinate reads, differences, squares, then the
// root unit at two digits a cycle. The last visit also runs the closing
// leg back to the first city, and then an emit step that waits while an
// earlier result is still unaccepted.
// Reset clears the tour state only; the coordinate store keeps no reset.
// A waiting result does not block loads or visits that produce no result.
// ----------------------------------------------------------------------------
module euclidean_tour_length import etl_pkg::*; #(
  parameter int MAX_CITIES = MAX_CITIES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  logic                   command,
  input  logic [IDX_W-1:0]       city_index,
  input  logic [IN_COORD_W-1:0]  x_coord,
  input  logic [IN_COORD_W-1:0]  y_coord,
  input  logic                   last_city,
  output logic                   res_valid,
  input  logic                   res_ready,
  output logic [SUM_W-1:0]       tour_length,
  output logic                   saturated
);

  localparam int ADDR_W = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
  localparam int LIM_W  = 17;
  localparam int EXT_W  = IN_COORD_W + COORD_BITS;
  localparam int RIN_W  = 2 * COORD_BITS + 1;
  localparam int ROOT_W = COORD_BITS + 1 + FRAC_BITS;
  localparam int ACC_W  = ((ROOT_W > SUM_W) ? ROOT_W : SUM_W) + 1;

  state_t state;
  state_t state_next;

  logic                         accept;
  logic                         mem_we;
  logic [ADDR_W-1:0]            mem_raddr;
  logic                         rd_oor_next;
  logic [COORD_BITS-1:0]        mem_rx;
  logic [COORD_BITS-1:0]        mem_ry;
  logic [EXT_W-1:0]             x_ext;
  logic [EXT_W-1:0]             y_ext;
  logic                         sqrt_start;
  logic                         sqrt_busy;
  logic [ROOT_W-1:0]            leg;
  logic [RIN_W-1:0]             radicand;

  logic [IDX_W-1:0]             first_city;
  logic [IDX_W-1:0]             previous_city;
  logic [IDX_W-1:0]             cur_city;
  logic                         last_flag;
  logic                         closing;
  logic                         in_tour;
  logic                         rd_oor;
  logic [SUM_W-1:0]             running_sum;
  logic                         sum_saturated;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by;
  logic signed [COORD_BITS-1:0] rd_xm;
  logic signed [COORD_BITS-1:0] rd_ym;
  logic signed [COORD_BITS:0]   diff_x;
  logic signed [COORD_BITS:0]   diff_y;
  logic [COORD_BITS:0]          abs_x;
  logic [COORD_BITS:0]          abs_y;
  logic [COORD_BITS-1:0]        dx;
  logic [COORD_BITS-1:0]        dy;
  logic [2*COORD_BITS-1:0]      px;
  logic [2*COORD_BITS-1:0]      py;
  logic [ACC_W-1:0]             total;

  function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] idx);
    logic [IDX_W+ADDR_W-1:0] wide;
    wide    = {{ADDR_W{1'b0}}, idx};
    to_addr = wide[ADDR_W-1:0];
  endfunction

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    in_range = ({{(LIM_W-IDX_W){1'b0}}, idx} < LIM_W'(MAX_CITIES));
  endfunction

  assign accept = cmd_valid && cmd_ready;

  // Coordinates are kept to COORD_BITS signed bits.
  assign x_ext = {{COORD_BITS{x_coord[IN_COORD_W-1]}}, x_coord};
  assign y_ext = {{COORD_BITS{y_coord[IN_COORD_W-1]}}, y_coord};

  etl_coord_mem #(
    .DEPTH      (MAX_CITIES),
    .COORD_BITS (COORD_BITS),
    .ADDR_W     (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (to_addr(city_index)),
    .wr_x    (x_ext[COORD_BITS-1:0]),
    .wr_y    (y_ext[COORD_BITS-1:0]),
    .rd_addr (mem_raddr),
    .rd_x    (mem_rx),
    .rd_y    (mem_ry)
  );

  assign radicand = {1'b0, px} + {1'b0, py};

  etl_sqrt #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS),
    .RIN_W      (RIN_W),
    .ROOT_W     (ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .busy     (sqrt_busy),
    .root     (leg)
  );

  // A city beyond the table reads as the origin.
  assign rd_xm  = rd_oor ? '0 : $signed(mem_rx);
  assign rd_ym  = rd_oor ? '0 : $signed(mem_ry);
  assign diff_x = {ax[COORD_BITS-1], ax} - {rd_xm[COORD_BITS-1], rd_xm};
  assign diff_y = {ay[COORD_BITS-1], ay} - {rd_ym[COORD_BITS-1], rd_ym};
  assign abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
  assign abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
  assign total  = ACC_W'(running_sum) + ACC_W'(leg);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd_ready   = 1'b0;
    mem_we      = 1'b0;
    mem_raddr   = '0;
    rd_oor_next = rd_oor;
    sqrt_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd_ready   = 1'b1;
        mem_raddr   = to_addr(previous_city);
        rd_oor_next = !in_range(previous_city);
        if (accept) begin
          if (command == CMD_LOAD) begin
            mem_we = in_range(city_index);
          end else if (!in_tour) begin
            if (last_city) begin
              state_next = ST_EMIT;
            end
          end else begin
            state_next = ST_RD_B;
          end
        end
      end
      ST_RD_B: begin
        mem_raddr   = to_addr(cur_city);
        rd_oor_next = !in_range(cur_city);
        state_next  = ST_DIFF;
      end
      ST_DIFF: begin
        state_next = ST_MUL;
      end
      ST_MUL: begin
        state_next = ST_START;
      end
      ST_START: begin
        sqrt_start = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (!sqrt_busy) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        mem_raddr   = to_addr(first_city);
        rd_oor_next = !in_range(first_city);
        if (last_flag && !closing) begin
          state_next = ST_DIFF;
        end else if (last_flag) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!res_valid || res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Tour control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_city    <= '0;
      previous_city <= '0;
      running_sum   <= '0;
      in_tour       <= 1'b0;
      sum_saturated <= 1'b0;
      closing       <= 1'b0;
      last_flag     <= 1'b0;
      rd_oor        <= 1'b0;
      res_valid     <= 1'b0;
    end else begin
      rd_oor <= rd_oor_next;
      if (res_valid && res_ready && state != ST_EMIT) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && command == CMD_VISIT) begin
            last_flag <= last_city;
            closing   <= 1'b0;
            if (!in_tour) begin
              first_city    <= city_index;
              previous_city <= city_index;
              running_sum   <= '0;
              sum_saturated <= 1'b0;
              in_tour       <= !last_city;
            end
          end
        end
        ST_ACC: begin
          if (total >= {{(ACC_W-SUM_W){1'b0}}, SUM_MAX}) begin
            running_sum   <= SUM_MAX;
            sum_saturated <= 1'b1;
          end else begin
            running_sum <= total[SUM_W-1:0];
          end
          if (!closing) begin
            previous_city <= cur_city;
          end
          if (last_flag && !closing) begin
            closing <= 1'b1;
          end else if (last_flag) begin
            in_tour <= 1'b0;
          end
        end
        ST_EMIT: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept) begin
      cur_city <= city_index;
    end
    if (state == ST_RD_B) begin
      ax <= rd_xm;
      ay <= rd_ym;
    end
    if (state == ST_DIFF) begin
      bx <= rd_xm;
      by <= rd_ym;
      dx <= abs_x[COORD_BITS-1:0];
      dy <= abs_y[COORD_BITS-1:0];
    end
    if (state == ST_MUL) begin
      px <= dx * dx;
      py <= dy * dy;
    end
    // The closing leg starts from the city just visited.
    if (state == ST_ACC) begin
      ax <= bx;
      ay <= by;
    end
    if (state == ST_EMIT && (!res_valid || res_ready)) begin
      tour_length <= running_sum;
      saturated   <= sum_saturated;
    end
  end

endmodule

// File: rtl/core/etl_coord_mem.sv
// ----------------------------------------------------------------------------
// etl_coord_mem: city coordinate store
// Two synchronous arrays (x and y) sharing one write and one read address,
// with registered read data.
// ----------------------------------------------------------------------------
module etl_coord_mem import etl_pkg::*; #(
  parameter int DEPTH      = MAX_CITIES_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int ADDR_W     = $clog2(DEPTH)
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [ADDR_W-1:0]     wr_addr,
  input  logic [COORD_BITS-1:0] wr_x,
  input  logic [COORD_BITS-1:0] wr_y,
  input  logic [ADDR_W-1:0]     rd_addr,
  output logic [COORD_BITS-1:0] rd_x,
  output logic [COORD_BITS-1:0] rd_y
);

  logic [COORD_BITS-1:0] x_store [DEPTH];
  logic [COORD_BITS-1:0] y_store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_store[wr_addr] <= wr_x;
      y_store[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    rd_x <= x_store[rd_addr];
    rd_y <= y_store[rd_addr];
  end

endmodule

// File: rtl/core/etl_sqrt.sv
// ----------------------------------------------------------------------------
// etl_sqrt: iterative fixed-point square root
// Digit-by-digit restoring root, two result bits per cycle, giving
// floor(sqrt(radicand) * 2^FRAC_BITS).
// ----------------------------------------------------------------------------
module etl_sqrt import etl_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int RIN_W      = 2 * COORD_BITS + 1,
  parameter int ROOT_W     = COORD_BITS + 1 + FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RIN_W-1:0]  radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  localparam int RAD_W = 2 * (COORD_BITS + 1);
  localparam int REM_W = ROOT_W + 3;
  localparam int STEPS = ROOT_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [CNT_W-1:0]  cnt;
  logic [REM_W+ROOT_W-1:0] step_a;
  logic [REM_W+ROOT_W-1:0] step_b;

  // One root digit: bring down a radicand pair and try (4 * root + 1).
  function automatic logic [REM_W+ROOT_W-1:0] root_step(
    input logic [REM_W-1:0]  r,
    input logic [ROOT_W-1:0] q,
    input logic [1:0]        pair
  );
    logic [REM_W-1:0] r_sh;
    logic [REM_W-1:0] trial;
    r_sh  = {r[REM_W-3:0], pair};
    trial = {1'b0, q, 2'b01};
    if (r_sh >= trial) begin
      root_step = {r_sh - trial, q[ROOT_W-2:0], 1'b1};
    end else begin
      root_step = {r_sh, q[ROOT_W-2:0], 1'b0};
    end
  endfunction

  always_comb begin
    step_a = root_step(rem, root, rad[RAD_W-1 -: 2]);
    step_b = root_step(step_a[REM_W+ROOT_W-1 -: REM_W], step_a[ROOT_W-1:0],
                       rad[RAD_W-3 -: 2]);
  end

  assign busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(STEPS);
    end else if (cnt >= CNT_W'(2)) begin
      cnt <= cnt - CNT_W'(2);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Once the real pairs are used up, zeros shift in for the fraction digits.
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= {1'b0, radicand};
      rem  <= '0;
      root <= '0;
    end else if (cnt >= CNT_W'(2)) begin
      rad  <= {rad[RAD_W-5:0], 4'b0000};
      rem  <= step_b[REM_W+ROOT_W-1 -: REM_W];
      root <= step_b[ROOT_W-1:0];
    end else if (cnt != '0) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= step_a[REM_W+ROOT_W-1 -: REM_W];
      root <= step_a[ROOT_W-1:0];
    end
  end

endmodule
